[rtl/bts_pkg.sv]
package bts_pkg;

    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int BankColW  = ColW - 1;
    localparam int BankRowW  = RowW - 1;
    localparam int BankAw    = BankColW + BankRowW;
    localparam int DimW      = 9;
    localparam int CoordW    = 17;
    localparam int TexelW    = 24;
    localparam int ChanW     = 8;
    localparam int OutW      = 16;
    localparam int NumBanks  = 4;

    localparam logic [CoordW-1:0] CoordOne = CoordW'(65536);

    localparam logic [0:0] OpWrite  = 1'b0;
    localparam logic [0:0] OpSample = 1'b1;

    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    typedef logic [TexelW-1:0] texel_t;

    // Per-bank access: the bank number is {row parity, column parity}.
    typedef struct packed {
        logic               we;
        logic [BankAw-1:0]  waddr;
        texel_t             wdata;
        logic [BankAw-1:0]  raddr;
    } bank_req_t;

endpackage

[rtl/bts_bank_ram.sv]
module bts_bank_ram
    import bts_pkg::*;
(
    input  logic      clk,
    input  bank_req_t req,
    output texel_t    rdata
);

    texel_t mem [2**BankAw];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

[rtl/bts_addr.sv]
module bts_addr
    import bts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample,
    input  logic [CoordW-1:0] u_coord,
    input  logic [CoordW-1:0] v_coord,
    input  logic [DimW-1:0]   tex_width,
    input  logic [DimW-1:0]   tex_height,
    output logic              addr_vld,
    output logic [ColW-1:0]   x0,
    output logic [ColW-1:0]   x1,
    output logic [RowW-1:0]   y0,
    output logic [RowW-1:0]   y1,
    output logic [7:0]        wx,
    output logic [7:0]        wy
);

    logic [CoordW-1:0] u_sat;
    logic [CoordW-1:0] v_inv;
    logic [DimW-1:0]   w_eff;
    logic [DimW-1:0]   h_eff;
    logic [DimW-1:0]   wm1;
    logic [DimW-1:0]   hm1;
    logic [CoordW+DimW-1:0] xf;
    logic [CoordW+DimW-1:0] yf;
    logic [CoordW+DimW-17:0] xi;
    logic [CoordW+DimW-17:0] yi;
    logic [CoordW+DimW-17:0] x1w;
    logic [CoordW+DimW-17:0] y1w;

    // Saturate coordinates, invert v and clamp the dimensions into range.
    always_comb
    begin
        u_sat = (u_coord > CoordOne) ? CoordOne : u_coord;
        v_inv = CoordOne - ((v_coord > CoordOne) ? CoordOne : v_coord);
        w_eff = (tex_width == '0) ? DimW'(1)
              : ((tex_width > DimW'(MaxWidth)) ? DimW'(MaxWidth) : tex_width);
        h_eff = (tex_height == '0) ? DimW'(1)
              : ((tex_height > DimW'(MaxHeight)) ? DimW'(MaxHeight) : tex_height);
        wm1 = w_eff - DimW'(1);
        hm1 = h_eff - DimW'(1);
        xf = (CoordW+DimW)'(u_sat) * (CoordW+DimW)'(wm1);
        yf = (CoordW+DimW)'(v_inv) * (CoordW+DimW)'(hm1);
        xi = xf[CoordW+DimW-1:16];
        yi = yf[CoordW+DimW-1:16];
        if (xi > (CoordW+DimW-16)'(wm1))
        begin
            xi = (CoordW+DimW-16)'(wm1);
        end
        if (yi > (CoordW+DimW-16)'(hm1))
        begin
            yi = (CoordW+DimW-16)'(hm1);
        end
        x1w = (xi + 1'b1 < (CoordW+DimW-16)'(w_eff)) ? xi + 1'b1 : (CoordW+DimW-16)'(wm1);
        y1w = (yi + 1'b1 < (CoordW+DimW-16)'(h_eff)) ? yi + 1'b1 : (CoordW+DimW-16)'(hm1);
    end

    // Stage register holding the four neighbour positions and weights.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_vld <= 1'b0;
        end
        else
        begin
            addr_vld <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        x0 <= xi[ColW-1:0];
        x1 <= x1w[ColW-1:0];
        y0 <= yi[RowW-1:0];
        y1 <= y1w[RowW-1:0];
        wx <= xf[15:8];
        wy <= yf[15:8];
    end

endmodule

[rtl/bts_blend.sv]
module bts_blend
    import bts_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    input  texel_t         c00,
    input  texel_t         c10,
    input  texel_t         c01,
    input  texel_t         c11,
    input  logic [7:0]     wx,
    input  logic [7:0]     wy,
    output logic           out_vld,
    output logic [OutW-1:0] red,
    output logic [OutW-1:0] green,
    output logic [OutW-1:0] blue
);

    logic [OutW-1:0] top_reg [3];
    logic [OutW-1:0] bot_reg [3];
    logic [7:0]      wy_reg;
    logic            h_vld_reg;
    logic [OutW-1:0] fin [3];
    logic [OutW-1:0] top [3];
    logic [OutW-1:0] bot [3];
    logic [8:0]      wxi;
    logic [8:0]      wyi;
    logic [OutW+7:0] acc [3];

    // Horizontal blend, one product pair per channel.
    always_comb
    begin
        wxi = 9'd256 - {1'b0, wx};
        for (int k = 0; k < 3; k++)
        begin
            top[k] = OutW'(c00[16-8*k +: 8]) * OutW'(wxi) + OutW'(c10[16-8*k +: 8]) * OutW'(wx);
            bot[k] = OutW'(c01[16-8*k +: 8]) * OutW'(wxi) + OutW'(c11[16-8*k +: 8]) * OutW'(wx);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            top_reg[k] <= top[k];
            bot_reg[k] <= bot[k];
        end
        wy_reg <= wy;
    end

    // Vertical blend, truncated to eight fraction bits.
    always_comb
    begin
        wyi = 9'd256 - {1'b0, wy_reg};
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = (OutW+8)'(top_reg[k]) * (OutW+8)'(wyi)
                   + (OutW+8)'(bot_reg[k]) * (OutW+8)'(wy_reg);
            fin[k] = acc[k][OutW+7:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
            out_vld   <= 1'b0;
        end
        else
        begin
            h_vld_reg <= in_vld;
            out_vld   <= h_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red   <= fin[0];
        green <= fin[1];
        blue  <= fin[2];
    end

endmodule

[rtl/bilinear_texture_sampler_unit.sv]
// Bilinear texture sampler, clamp to edge, 8-bit RGB texels.
// Input beats are taken on start while busy is low; busy is always low,
// so one beat may enter every cycle. A beat with op = 0 writes one texel
// into the texel store and produces nothing. A beat with op = 1 samples at
// u_coord, v_coord and yields one result beat on red_out, green_out and
// blue_out, marked by done for exactly one cycle.
// A sample passes the address stage, loaded at the accepting edge, then
// store read, horizontal blend and vertical blend; done rises with the
// vertical blend result.
// Throughput: one beat per cycle, set by the four-bank texel store split by
// row and column parity, so the four neighbours come from four banks.
// Writes and samples both reach the store at the edge after acceptance,
// so the store sees them in the order they were accepted.
// tex_width and tex_height are written through cfg_we, cfg_index, cfg_data
// while the block is idle. Reset sets both to 256 and clears the pipeline
// valid bits; the texel store is not cleared and holds garbage until
// written. The receiver cannot stall, so results are never held back.
module bilinear_texture_sampler_unit
    import bts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [DimW-1:0]   cfg_data,
    input  logic [0:0]        op,
    input  logic [ColW-1:0]   texel_col,
    input  logic [RowW-1:0]   texel_row,
    input  logic [ChanW-1:0]  red_in,
    input  logic [ChanW-1:0]  green_in,
    input  logic [ChanW-1:0]  blue_in,
    input  logic [CoordW-1:0] u_coord,
    input  logic [CoordW-1:0] v_coord,
    output logic              done,
    output logic [OutW-1:0]   red_out,
    output logic [OutW-1:0]   green_out,
    output logic [OutW-1:0]   blue_out
);

    logic [DimW-1:0] width_reg;
    logic [DimW-1:0] height_reg;
    logic            accept;
    logic            wr_vld_reg;
    logic [ColW-1:0] wr_col_reg;
    logic [RowW-1:0] wr_row_reg;
    texel_t          wr_data_reg;
    logic            addr_vld;
    logic [ColW-1:0] x0;
    logic [ColW-1:0] x1;
    logic [RowW-1:0] y0;
    logic [RowW-1:0] y1;
    logic [7:0]      wx;
    logic [7:0]      wy;
    bank_req_t       req [NumBanks];
    texel_t          rdata [NumBanks];
    logic            rd_vld_reg;
    logic            x0_odd_reg;
    logic            y0_odd_reg;
    logic [7:0]      wx_reg;
    logic [7:0]      wy_reg;
    texel_t          c00;
    texel_t          c10;
    texel_t          c01;
    texel_t          c11;
    logic            xs_reg;
    logic            ys_reg;
    texel_t          c10_fix;
    texel_t          c01_fix;
    texel_t          c11_fix;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DimW'(256);
            height_reg <= DimW'(256);
        end
        else if (cfg_we)
        begin
            if (cfg_index == RegWidth)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Write beats wait one stage so they stay in order with samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_vld_reg <= 1'b0;
        end
        else
        begin
            wr_vld_reg <= accept && (op == OpWrite);
        end
    end

    always_ff @(posedge clk)
    begin
        wr_col_reg  <= texel_col;
        wr_row_reg  <= texel_row;
        wr_data_reg <= {red_in, green_in, blue_in};
    end

    bts_addr u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (accept && (op == OpSample)),
        .u_coord    (u_coord),
        .v_coord    (v_coord),
        .tex_width  (width_reg),
        .tex_height (height_reg),
        .addr_vld   (addr_vld),
        .x0         (x0),
        .x1         (x1),
        .y0         (y0),
        .y1         (y1),
        .wx         (wx),
        .wy         (wy)
    );

    // Route each neighbour to the bank of its row and column parity.
    always_comb
    begin
        for (int b = 0; b < NumBanks; b++)
        begin
            logic [ColW-1:0] cx;
            logic [RowW-1:0] ry;
            cx = (x0[0] == b[0]) ? x0 : x1;
            ry = (y0[0] == b[1]) ? y0 : y1;
            req[b].raddr = {ry[RowW-1:1], cx[ColW-1:1]};
            req[b].we    = wr_vld_reg && (wr_col_reg[0] == b[0])
                           && (wr_row_reg[0] == b[1]);
            req[b].waddr = {wr_row_reg[RowW-1:1], wr_col_reg[ColW-1:1]};
            req[b].wdata = wr_data_reg;
        end
    end

    for (genvar g = 0; g < NumBanks; g++)
    begin : g_bank
        bts_bank_ram u_ram (
            .clk   (clk),
            .req   (req[g]),
            .rdata (rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= addr_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_odd_reg <= x0[0];
        y0_odd_reg <= y0[0];
        wx_reg     <= wx;
        wy_reg     <= wy;
    end

    // Undo the parity routing on the read data.
    always_comb
    begin
        c00 = rdata[{y0_odd_reg, x0_odd_reg}];
        c10 = rdata[{y0_odd_reg, !x0_odd_reg}];
        c01 = rdata[{!y0_odd_reg, x0_odd_reg}];
        c11 = rdata[{!y0_odd_reg, !x0_odd_reg}];
    end

    bts_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (rd_vld_reg),
        .c00     (c00),
        .c10     (c10_fix),
        .c01     (c01_fix),
        .c11     (c11_fix),
        .wx      (wx_reg),
        .wy      (wy_reg),
        .out_vld (done),
        .red     (red_out),
        .green   (green_out),
        .blue    (blue_out)
    );

    // Clamped neighbours equal their partners; track that per stage.
    always_ff @(posedge clk)
    begin
        xs_reg <= (x0 == x1);
        ys_reg <= (y0 == y1);
    end

    always_comb
    begin
        c10_fix = xs_reg ? c00 : c10;
        c01_fix = ys_reg ? c00 : c01;
        c11_fix = ys_reg ? c10_fix : (xs_reg ? c01 : c11);
    end

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && op == OpWrite) |=> !addr_vld)
        else $error("write beat entered the sample path");

    a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_vld_reg && addr_vld))
        else $error("write and sample in the same stage");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |=> ##1 done)
        else $error("sample result lost");

endmodule
